### hdl/immr_pkg.sv
// Shared types, constants and helpers for the interrupt mask and mode register block.
package immr_pkg;

    // Field widths of one request and one result.
    localparam int unsigned ActionW   = 2;
    localparam int unsigned OffsetW   = 4;
    localparam int unsigned DataW     = 32;
    localparam int unsigned SrcW      = 6;
    localparam int unsigned ModeW     = 10;
    localparam int unsigned ModeLowW  = 7;

    // Stream payload widths, padded to whole bytes.
    localparam int unsigned InPackW   = OffsetW + DataW + SrcW;
    localparam int unsigned InTdataW  = ((InPackW + 7) / 8) * 8;
    localparam int unsigned OutPackW  = DataW + 1;
    localparam int unsigned OutTdataW = ((OutPackW + 7) / 8) * 8;

    // Register offsets within the four-bit window.
    localparam logic [OffsetW-1:0] OFF_MODE    = 4'd0;
    localparam logic [OffsetW-1:0] OFF_VERSION = 4'd4;
    localparam logic [OffsetW-1:0] OFF_PENDING = 4'd8;
    localparam logic [OffsetW-1:0] OFF_MASK    = 4'd12;

    // Fixed version word returned at the version offset.
    localparam logic [DataW-1:0] VERSION_WORD = 32'h0202_0102;

    // Source bit position of the DP interrupt.
    localparam int unsigned DP_BIT = 5;

    // Mode write control bit positions: set and clear pairs, and the DP clear bit.
    localparam int unsigned MODE9_SET = 13;
    localparam int unsigned MODE9_CLR = 12;
    localparam int unsigned DP_CLR    = 11;
    localparam int unsigned MODE8_SET = 10;
    localparam int unsigned MODE8_CLR = 9;
    localparam int unsigned MODE7_SET = 8;
    localparam int unsigned MODE7_CLR = 7;

    // Kind of request carried on tuser.
    typedef enum logic [ActionW-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RAISE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // One captured request.
    typedef struct packed {
        action_t              action;
        logic [OffsetW-1:0]   offset;
        logic [DataW-1:0]     write_data;
        logic [SrcW-1:0]      source_bits;
    } req_t;

    // Set/clear pair update of one bit: both set keeps the current value.
    function automatic logic pair_update(input logic cur, input logic set_b,
                                         input logic clr_b);
        logic res;
        res = cur;
        if (set_b && !clr_b)
        begin
            res = 1'b1;
        end
        else if (clr_b && !set_b)
        begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

### hdl/interrupt_mask_mode_registers.sv
// Interrupt controller with mode, pending and mask registers behind a stream port.
//
// Channel   Dir  tdata (low bit up)                            tuser
// s_axis    in   offset[3:0], write_data[35:4], source[41:36]  action[1:0]
// m_axis    out  read_data[31:0], irq_line[32]                 -
//
// Each request passes through the input register and then the result register;
// one request is accepted per cycle while m_axis does not stall.
// The register update is done in a single pass as a request leaves the input
// register, so requests act on the state strictly in order.
// Reset clears the mode, pending and mask registers and empties both stages.
// A stall on m_axis holds the result register and then the input register.
module interrupt_mask_mode_registers (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // offset, write_data, source_bits, zero padding
    input  logic [immr_pkg::InTdataW-1:0]    s_axis_tdata,
    // action
    input  logic [immr_pkg::ActionW-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data, irq_line, zero padding
    output logic [immr_pkg::OutTdataW-1:0]   m_axis_tdata
);

    // Input stage.
    immr_pkg::req_t                    req_reg;
    logic                              in_valid_reg;

    // Result stage.
    logic                              out_valid_reg;
    logic [immr_pkg::DataW-1:0]        rd_reg;
    logic                              irq_reg;

    // Architectural state.
    logic [immr_pkg::ModeW-1:0]        mode_reg;
    logic [immr_pkg::SrcW-1:0]         pending_reg;
    logic [immr_pkg::SrcW-1:0]         mask_reg;

    logic [immr_pkg::ModeW-1:0]        mode_next;
    logic [immr_pkg::SrcW-1:0]         pending_next;
    logic [immr_pkg::SrcW-1:0]         mask_next;
    logic [immr_pkg::DataW-1:0]        rd_next;

    logic                              out_load;
    logic                              advance;

    // Stage flow: the result register loads when empty or being drained.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;

    // Capture the incoming request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            req_reg.action      <= immr_pkg::action_t'(s_axis_tuser);
            req_reg.offset      <= s_axis_tdata[immr_pkg::OffsetW-1:0];
            req_reg.write_data  <= s_axis_tdata[immr_pkg::OffsetW +: immr_pkg::DataW];
            req_reg.source_bits <=
                s_axis_tdata[immr_pkg::OffsetW + immr_pkg::DataW +: immr_pkg::SrcW];
        end
    end

    // Register update and read data for the request in the input register.
    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        mask_next    = mask_reg;
        rd_next      = '0;
        unique case (req_reg.action)
            immr_pkg::ACT_READ:
            begin
                case (req_reg.offset)
                    immr_pkg::OFF_MODE:
                        rd_next = {{(immr_pkg::DataW - immr_pkg::ModeW){1'b0}}, mode_reg};
                    immr_pkg::OFF_VERSION:
                        rd_next = immr_pkg::VERSION_WORD;
                    immr_pkg::OFF_PENDING:
                        rd_next = {{(immr_pkg::DataW - immr_pkg::SrcW){1'b0}}, pending_reg};
                    immr_pkg::OFF_MASK:
                        rd_next = {{(immr_pkg::DataW - immr_pkg::SrcW){1'b0}}, mask_reg};
                    default:
                        rd_next = '0;
                endcase
            end
            immr_pkg::ACT_WRITE:
            begin
                case (req_reg.offset)
                    immr_pkg::OFF_MODE:
                    begin
                        mode_next[9] = immr_pkg::pair_update(mode_reg[9],
                            req_reg.write_data[immr_pkg::MODE9_SET],
                            req_reg.write_data[immr_pkg::MODE9_CLR]);
                        mode_next[8] = immr_pkg::pair_update(mode_reg[8],
                            req_reg.write_data[immr_pkg::MODE8_SET],
                            req_reg.write_data[immr_pkg::MODE8_CLR]);
                        mode_next[7] = immr_pkg::pair_update(mode_reg[7],
                            req_reg.write_data[immr_pkg::MODE7_SET],
                            req_reg.write_data[immr_pkg::MODE7_CLR]);
                        mode_next[immr_pkg::ModeLowW-1:0] =
                            req_reg.write_data[immr_pkg::ModeLowW-1:0];
                        if (req_reg.write_data[immr_pkg::DP_CLR])
                        begin
                            pending_next[immr_pkg::DP_BIT] = 1'b0;
                        end
                    end
                    immr_pkg::OFF_MASK:
                    begin
                        // Each mask bit has a clear bit below its set bit.
                        for (int k = 0; k < immr_pkg::SrcW; k++)
                        begin
                            mask_next[k] = immr_pkg::pair_update(mask_reg[k],
                                req_reg.write_data[2*k+1], req_reg.write_data[2*k]);
                        end
                    end
                    default:
                        mode_next = mode_reg;
                endcase
            end
            immr_pkg::ACT_RAISE:
                pending_next = pending_reg | req_reg.source_bits;
            immr_pkg::ACT_CLEAR:
                pending_next = pending_reg & ~req_reg.source_bits;
            default:
                rd_next = '0;
        endcase
    end

    // State registers advance with each request that leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            pending_reg <= '0;
            mask_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg  <= rd_next;
            irq_reg <= |(pending_next & mask_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(immr_pkg::OutTdataW - immr_pkg::OutPackW){1'b0}}, irq_reg, rd_reg};

endmodule
